// ===== hw/rtl/vfpq_pkg.sv =====
// ----------------------------------------------------------------------------
// vfpq_pkg
// Shared constants, command codes and configuration types for the video
// frame pacing queue.
// ----------------------------------------------------------------------------
package vfpq_pkg;

  // Default sizing of the queue and its fields
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF   = 48;
  localparam int HANDLE_BITS_DEF = 16;

  // Command codes carried by an input item
  localparam logic [2:0] CMD_DEC_UPDATE = 3'd0;
  localparam logic [2:0] CMD_DISP_TICK  = 3'd1;
  localparam logic [2:0] CMD_SEEK       = 3'd2;
  localparam logic [2:0] CMD_SAMPLE_WR  = 3'd3;
  localparam logic [2:0] CMD_EOS_WR     = 3'd4;

  // Register widths
  localparam int FRAMES_W = 5;
  localparam int THRESH_W = 17;

  // Register file
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_PREROLL   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_CACHE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

  // 90 kHz media clock; default slack is 1/250 s
  localparam int MEDIA_TICKS_PER_SEC = 90000;
  localparam logic [FRAMES_W-1:0] PREROLL_RST   = 5'd1;
  localparam logic [FRAMES_W-1:0] MAX_CACHE_RST = 5'd12;
  localparam logic [THRESH_W-1:0] THRESHOLD_RST = THRESH_W'(MEDIA_TICKS_PER_SEC / 250);

  typedef struct packed {
    logic [FRAMES_W-1:0] preroll_frames;
    logic [FRAMES_W-1:0] max_cached_frames;
    logic [THRESH_W-1:0] time_threshold;
  } cfg_t;

endpackage

// ===== hw/rtl/vfpq_cfg.sv =====
// ----------------------------------------------------------------------------
// vfpq_cfg
// APB register file holding preroll, cache limit and timestamp slack.
// ----------------------------------------------------------------------------
module vfpq_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vfpq_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [vfpq_pkg::APB_DATA_W-1:0] pwdata,
  output logic [vfpq_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output vfpq_pkg::cfg_t                  cfg
);
  import vfpq_pkg::*;

  cfg_t                 cfg_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preroll_frames    <= PREROLL_RST;
      cfg_r.max_cached_frames <= MAX_CACHE_RST;
      cfg_r.time_threshold    <= THRESHOLD_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PREROLL:   cfg_r.preroll_frames    <= pwdata[FRAMES_W-1:0];
        REG_MAX_CACHE: cfg_r.max_cached_frames <= pwdata[FRAMES_W-1:0];
        REG_THRESHOLD: cfg_r.time_threshold    <= pwdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PREROLL:   prdata = APB_DATA_W'(cfg_r.preroll_frames);
      REG_MAX_CACHE: prdata = APB_DATA_W'(cfg_r.max_cached_frames);
      REG_THRESHOLD: prdata = APB_DATA_W'(cfg_r.time_threshold);
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/vfpq_store.sv =====
// ----------------------------------------------------------------------------
// vfpq_store
// Frame entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vfpq_store #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

// ===== hw/rtl/video_frame_pacing_queue.sv =====
// ----------------------------------------------------------------------------
// video_frame_pacing_queue
// Queue of decoded video frames paced against the audio clock.
// ----------------------------------------------------------------------------
// The block keeps up to QUEUE_DEPTH decoded frames (handle and timestamp) in a
// single-port-read frame memory and answers every input item with exactly one
// status item: the chosen frame, the drop count, seek state, input
// flow control, end-of-stream state, queue fill and an overflow flag. Every
// command except a display tick on a non-empty queue completes in the cycle
// it is accepted, and its status item is registered on the accepting edge.
// A display tick on a non-empty queue walks the queue head: from the cycle
// after acceptance it examines one head entry per cycle, read from the frame
// memory, and either pops it or settles on it; settling waits until the
// output register is free. A tick pops at most QUEUE_DEPTH - 1 frames. One
// item is in work at a time, and a new item is taken once the previous
// status item has left or is leaving the output register. Registers sit on
// an APB-style port: preroll_frames at 0x0, max_cached_frames at 0x4,
// time_threshold at 0x8; write them only while the block is idle. After reset
// the frame memory holds nothing meaningful, but only entries inside the
// current fill are ever read.
// ----------------------------------------------------------------------------
module video_frame_pacing_queue #(
  parameter int QUEUE_DEPTH = vfpq_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = vfpq_pkg::TIME_BITS_DEF,
  parameter int HANDLE_BITS = vfpq_pkg::HANDLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input item channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          in_command,
  input  logic                                in_frame_present,
  input  logic [HANDLE_BITS-1:0]              in_frame_handle,
  input  logic                                in_frame_is_eos,
  input  logic signed [TIME_BITS-1:0]         in_frame_pts,
  input  logic                                in_decoder_needs_input,
  input  logic signed [TIME_BITS-1:0]         in_audio_time,
  input  logic                                in_audio_eos,
  input  logic signed [TIME_BITS-1:0]         in_seek_pts,
  // status item channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_current_valid,
  output logic [HANDLE_BITS-1:0]              out_current_handle,
  output logic [31:0]                         out_dropped_count,
  output logic                                out_seeking,
  output logic                                out_can_accept,
  output logic                                out_eos_played,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]    out_queue_count,
  output logic                                out_overflow,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vfpq_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [vfpq_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [vfpq_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import vfpq_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > FRAMES_W) ? CNT_W : FRAMES_W;
  localparam int ENT_W = TIME_BITS + HANDLE_BITS;
  // Two guard bits keep pts +/- threshold exact
  localparam int EXT_W = TIME_BITS + 2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  cfg_t cfg;

  // Control state
  state_t                       state_r, state_nxt;
  logic [PTR_W-1:0]             head_r, head_nxt;
  logic [CNT_W-1:0]             fill_r, fill_nxt;
  logic                         fic_r, fic_nxt;
  logic [HANDLE_BITS-1:0]       cur_id_r, cur_id_nxt;
  logic                         cur_known_r, cur_known_nxt;
  logic                         seek_r, seek_nxt;
  logic signed [TIME_BITS-1:0]  seek_tgt_r, seek_tgt_nxt;
  logic                         eos_wr_r, eos_wr_nxt;
  logic                         need_in_r, need_in_nxt;
  logic [31:0]                  drop_r, drop_nxt;
  logic                         first_r, first_nxt;
  // Tick operands held for the walk
  logic signed [TIME_BITS-1:0]  mt_r, mt_nxt;
  logic                         aeos_r, aeos_nxt;

  // Status item register
  logic                         out_valid_r;
  logic                         o_cur_valid_r;
  logic [HANDLE_BITS-1:0]       o_cur_handle_r;
  logic [31:0]                  o_dropped_r;
  logic                         o_seeking_r;
  logic                         o_can_accept_r;
  logic                         o_eos_played_r;
  logic [CNT_W-1:0]             o_count_r;
  logic                         o_overflow_r;

  // Per-cycle control
  logic                         fire;
  logic                         out_free;
  logic                         load_out;
  logic                         ovf;
  logic                         too_early;
  logic                         multi;
  logic                         do_pop;
  logic                         adv_ok;
  logic                         stale;
  logic [PTR_W-1:0]             head_inc;
  logic [PTR_W:0]               wr_sum;

  // Frame memory ports
  logic                         mem_we;
  logic [PTR_W-1:0]             mem_waddr;
  logic [ENT_W-1:0]             mem_wdata;
  logic [ENT_W-1:0]             mem_rdata;
  logic [HANDLE_BITS-1:0]       rd_handle;
  logic signed [TIME_BITS-1:0]  rd_pts;

  // Timestamp compare
  logic signed [EXT_W-1:0]      pts_e;
  logic signed [EXT_W-1:0]      mt_e;
  logic signed [EXT_W-1:0]      thr_e;
  logic signed [EXT_W-1:0]      pts_lo;
  logic signed [EXT_W-1:0]      pts_hi;

  vfpq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The read address follows the next head, so the entry at the head is
  // always waiting in the read register. Writes only come with a decoder
  // update, never on the edge that starts or continues a walk, so the
  // read and a write to the same entry never meet.
  vfpq_store #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENT_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (head_nxt),
    .rdata (mem_rdata)
  );

  assign rd_handle = mem_rdata[HANDLE_BITS-1:0];
  assign rd_pts    = mem_rdata[ENT_W-1:HANDLE_BITS];
  assign mem_wdata = {in_frame_pts, in_frame_handle};

  // Tail slot: head + fill, wrapped once
  assign wr_sum    = {1'b0, head_r} + {1'b0, fill_r[PTR_W-1:0]};
  assign mem_waddr = (wr_sum >= (PTR_W+1)'(QUEUE_DEPTH)) ?
                     PTR_W'(wr_sum - (PTR_W+1)'(QUEUE_DEPTH)) : wr_sum[PTR_W-1:0];

  assign head_inc = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);

  // Advance when pts - thr < media time; drop when pts + thr < media time
  assign pts_e  = {{2{rd_pts[TIME_BITS-1]}}, rd_pts};
  assign mt_e   = {{2{mt_r[TIME_BITS-1]}}, mt_r};
  assign thr_e  = {{(EXT_W-THRESH_W){1'b0}}, cfg.time_threshold};
  assign pts_lo = pts_e - thr_e;
  assign pts_hi = pts_e + thr_e;
  assign adv_ok = pts_lo < mt_e;
  assign stale  = pts_hi < mt_e;
  assign multi  = fill_r > CNT_W'(1);

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign fire     = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    fic_nxt       = fic_r;
    cur_id_nxt    = cur_id_r;
    cur_known_nxt = cur_known_r;
    seek_nxt      = seek_r;
    seek_tgt_nxt  = seek_tgt_r;
    eos_wr_nxt    = eos_wr_r;
    need_in_nxt   = need_in_r;
    drop_nxt      = drop_r;
    first_nxt     = first_r;
    mt_nxt        = mt_r;
    aeos_nxt      = aeos_r;
    load_out      = 1'b0;
    ovf           = 1'b0;
    mem_we        = 1'b0;
    too_early     = 1'b0;
    do_pop        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (fire) begin
          load_out = 1'b1;
          case (in_command)
            CMD_DEC_UPDATE: begin
              if (in_frame_present) begin
                // Discard frames earlier than the seek target; an end frame ends seeking
                if (seek_r) begin
                  if (in_frame_is_eos) begin
                    seek_nxt = 1'b0;
                  end else if (in_frame_pts < seek_tgt_r) begin
                    too_early = 1'b1;
                  end
                end
                if (!too_early) begin
                  if (fill_r == CNT_W'(QUEUE_DEPTH)) begin
                    ovf = 1'b1;
                  end else begin
                    mem_we   = 1'b1;
                    fill_nxt = fill_r + CNT_W'(1);
                  end
                end
                if (seek_nxt && (CMP_W'(fill_nxt) >= CMP_W'(cfg.preroll_frames))) begin
                  seek_nxt = 1'b0;
                end
              end
              need_in_nxt = in_decoder_needs_input;
            end
            CMD_DISP_TICK: begin
              mt_nxt   = in_audio_time;
              aeos_nxt = in_audio_eos;
              // Empty queue: report status and leave everything alone
              if (fill_r != '0) begin
                load_out  = 1'b0;
                first_nxt = 1'b1;
                state_nxt = ST_WALK;
              end
            end
            CMD_SEEK: begin
              seek_tgt_nxt = in_seek_pts[TIME_BITS-1] ? '0 : in_seek_pts;
              seek_nxt     = 1'b1;
              eos_wr_nxt   = 1'b0;
              need_in_nxt  = 1'b1;
              fill_nxt     = '0;
              head_nxt     = '0;
              fic_nxt      = 1'b0;
            end
            CMD_SAMPLE_WR: begin
              if (!eos_wr_r) begin
                need_in_nxt = 1'b0;
              end
            end
            CMD_EOS_WR: begin
              eos_wr_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (multi && first_r && fic_r && adv_ok) begin
          // Step past the frame already on screen
          do_pop = 1'b1;
        end else if (multi && stale) begin
          // Drop a late frame; count it only if it was never shown
          do_pop = 1'b1;
          if (!fic_r) begin
            drop_nxt = drop_r + 32'd1;
          end
        end else if (out_free) begin
          if (aeos_r) begin
            fill_nxt = CNT_W'(1);
          end
          cur_id_nxt    = rd_handle;
          cur_known_nxt = 1'b1;
          fic_nxt       = 1'b1;
          load_out      = 1'b1;
          state_nxt     = ST_IDLE;
        end
        if (do_pop) begin
          head_nxt  = head_inc;
          fill_nxt  = fill_r - CNT_W'(1);
          fic_nxt   = 1'b0;
          first_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      fic_r       <= 1'b0;
      cur_id_r    <= '0;
      cur_known_r <= 1'b0;
      seek_r      <= 1'b0;
      seek_tgt_r  <= '0;
      eos_wr_r    <= 1'b0;
      need_in_r   <= 1'b1;
      drop_r      <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      fic_r       <= fic_nxt;
      cur_id_r    <= cur_id_nxt;
      cur_known_r <= cur_known_nxt;
      seek_r      <= seek_nxt;
      seek_tgt_r  <= seek_tgt_nxt;
      eos_wr_r    <= eos_wr_nxt;
      need_in_r   <= need_in_nxt;
      drop_r      <= drop_nxt;
      first_r     <= first_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Tick operands and status item payload
  always_ff @(posedge clk) begin
    mt_r   <= mt_nxt;
    aeos_r <= aeos_nxt;
    if (load_out) begin
      o_cur_valid_r  <= cur_known_nxt;
      o_cur_handle_r <= cur_id_nxt;
      o_dropped_r    <= drop_nxt;
      o_seeking_r    <= seek_nxt;
      o_can_accept_r <= (CMP_W'(fill_nxt) < CMP_W'(cfg.max_cached_frames)) &&
                        !eos_wr_nxt && need_in_nxt;
      o_eos_played_r <= eos_wr_nxt && (fill_nxt <= CNT_W'(1));
      o_count_r      <= fill_nxt;
      o_overflow_r   <= ovf;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_current_valid  = o_cur_valid_r;
  assign out_current_handle = o_cur_handle_r;
  assign out_dropped_count  = o_dropped_r;
  assign out_seeking        = o_seeking_r;
  assign out_can_accept     = o_can_accept_r;
  assign out_eos_played     = o_eos_played_r;
  assign out_queue_count    = o_count_r;
  assign out_overflow       = o_overflow_r;

  // Fill never passes the queue depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  // A head walk only runs on a non-empty queue
  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> fill_r != '0)
    else $error("head walk on empty queue");

  // Every command other than a tick reports on the next edge
  a_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_command != CMD_DISP_TICK |=> out_valid_r)
    else $error("status item missing after single-cycle command");

  // The drop counter moves only while walking the head
  a_drop_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r != $past(drop_r) |-> $past(state_r) == ST_WALK)
    else $error("drop count changed outside a tick");

  // The walk never ends without a frame chosen
  a_tick_chooses: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK && state_nxt == ST_IDLE |=> cur_known_r && fic_r)
    else $error("tick finished without a current frame");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the video frame pacing queue. A scoreboard class
// keeps its own model of the frame queue, the seek state and the drop count,
// predicts one status item per accepted input item and checks each status
// item the block returns. Stimulus is a short directed run over the corner
// cases, then random playback sessions (seek, decode, display ticks, end of
// stream) under several register settings, with bursty input traffic and a
// stalling output receiver.
// ----------------------------------------------------------------------------
module tb;
  import vfpq_pkg::*;

  localparam int DEPTH   = QUEUE_DEPTH_DEF;
  localparam int TBITS   = TIME_BITS_DEF;
  localparam int HBITS   = HANDLE_BITS_DEF;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int FRAME_T = 3000;    // one frame period at 30 fps, 90 kHz ticks

  // One input item, as driven onto the in_ ports
  typedef struct {
    logic [2:0]       command;
    logic             frame_present;
    logic [HBITS-1:0] frame_handle;
    logic             frame_is_eos;
    logic [TBITS-1:0] frame_pts;
    logic             decoder_needs_input;
    logic [TBITS-1:0] audio_time;
    logic             audio_eos;
    logic [TBITS-1:0] seek_pts;
  } frame_cmd_t;

  // One status item, as seen on the out_ ports
  typedef struct {
    logic             current_valid;
    logic [HBITS-1:0] current_handle;
    logic [31:0]      dropped_count;
    logic             seeking;
    logic             can_accept;
    logic             eos_played;
    logic [CNT_W-1:0] queue_count;
    logic             overflow;
  } pacing_status_t;

  // --------------------------------------------------------------------------
  // Scoreboard: frame queue model plus the store of expected status items
  // --------------------------------------------------------------------------
  class pacing_scoreboard;
    logic [FRAMES_W-1:0] preroll;
    logic [FRAMES_W-1:0] max_cache;
    logic [THRESH_W-1:0] thresh;

    logic [HBITS-1:0] q_handle [DEPTH];
    longint           q_pts    [DEPTH];
    int unsigned      head;
    int unsigned      fill;
    bit               front_cur;
    logic [HBITS-1:0] cur_id;
    bit               cur_known;
    bit               seek_on;
    longint           seek_tgt;
    bit               eos_wr;
    bit               need_in;
    logic [31:0]      drops;

    pacing_status_t   expected_status [$];
    int               errors;

    function new();
      preroll   = PREROLL_RST;
      max_cache = MAX_CACHE_RST;
      thresh    = THRESHOLD_RST;
      head      = 0;
      fill      = 0;
      front_cur = 0;
      cur_id    = '0;
      cur_known = 0;
      seek_on   = 0;
      seek_tgt  = 0;
      eos_wr    = 0;
      need_in   = 1;
      drops     = '0;
      errors    = 0;
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    function void drop_head();
      head      = (head + 1) % DEPTH;
      fill      = fill - 1;
      front_cur = 0;
    endfunction

    // Display tick: step past the shown frame once it is due, drop stale
    // frames, then settle on the head.
    function void display_tick(longint mt, bit audio_end);
      longint thr;
      thr = longint'(thresh);
      if (fill == 0) return;
      if (fill > 1 && front_cur && (q_pts[head] - thr < mt)) drop_head();
      while (fill > 1 && (q_pts[head] + thr < mt)) begin
        if (!front_cur) drops = drops + 1;
        drop_head();
      end
      if (audio_end) fill = 1;
      cur_id    = q_handle[head];
      cur_known = 1;
      front_cur = 1;
    endfunction

    function void note_command(frame_cmd_t c);
      pacing_status_t st;
      bit             ovf;
      bit             too_early;
      longint         pts;
      longint         sp;
      ovf = 0;
      case (c.command)
        CMD_DEC_UPDATE: begin
          if (c.frame_present) begin
            pts       = longint'($signed(c.frame_pts));
            too_early = 0;
            if (seek_on) begin
              if (c.frame_is_eos) seek_on = 0;
              else if (pts < seek_tgt) too_early = 1;
            end
            if (!too_early) begin
              if (fill >= DEPTH) begin
                ovf = 1;
              end else begin
                q_handle[(head + fill) % DEPTH] = c.frame_handle;
                q_pts[(head + fill) % DEPTH]    = pts;
                fill = fill + 1;
              end
            end
            if (seek_on && fill >= preroll) seek_on = 0;
          end
          need_in = c.decoder_needs_input;
        end
        CMD_DISP_TICK: display_tick(longint'($signed(c.audio_time)), c.audio_eos);
        CMD_SEEK: begin
          sp        = longint'($signed(c.seek_pts));
          seek_tgt  = (sp < 0) ? 0 : sp;
          seek_on   = 1;
          eos_wr    = 0;
          need_in   = 1;
          fill      = 0;
          head      = 0;
          front_cur = 0;
        end
        CMD_SAMPLE_WR: if (!eos_wr) need_in = 0;
        CMD_EOS_WR:    eos_wr = 1;
        default: ;
      endcase
      st.current_valid  = cur_known;
      st.current_handle = cur_id;
      st.dropped_count  = drops;
      st.seeking        = seek_on;
      st.can_accept     = (fill < max_cache) && !eos_wr && need_in;
      st.eos_played     = eos_wr && (fill <= 1);
      st.queue_count    = CNT_W'(fill);
      st.overflow       = ovf;
      expected_status.insert(expected_status.size(), st);
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_status(pacing_status_t got);
      pacing_status_t want;
      if (expected_status.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: status item with no expectation: expected none, actual count %0d",
                   $time, got.queue_count);
        return;
      end
      want = expected_status[0];
      expected_status.delete(0);
      check_field("current_valid",  64'(want.current_valid),  64'(got.current_valid));
      check_field("current_handle", 64'(want.current_handle), 64'(got.current_handle));
      check_field("dropped_count",  64'(want.dropped_count),  64'(got.dropped_count));
      check_field("seeking",        64'(want.seeking),        64'(got.seeking));
      check_field("can_accept",     64'(want.can_accept),     64'(got.can_accept));
      check_field("eos_played",     64'(want.eos_played),     64'(got.eos_played));
      check_field("queue_count",    64'(want.queue_count),    64'(got.queue_count));
      check_field("overflow",       64'(want.overflow),       64'(got.overflow));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT signals and instance
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  frame_cmd_t drv = '{default: '0};
  logic in_valid  = 1'b0;
  logic in_ready;
  logic out_ready = 1'b0;
  logic out_valid;
  logic             out_current_valid;
  logic [HBITS-1:0] out_current_handle;
  logic [31:0]      out_dropped_count;
  logic             out_seeking;
  logic             out_can_accept;
  logic             out_eos_played;
  logic [CNT_W-1:0] out_queue_count;
  logic             out_overflow;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  video_frame_pacing_queue u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_command             (drv.command),
    .in_frame_present       (drv.frame_present),
    .in_frame_handle        (drv.frame_handle),
    .in_frame_is_eos        (drv.frame_is_eos),
    .in_frame_pts           (drv.frame_pts),
    .in_decoder_needs_input (drv.decoder_needs_input),
    .in_audio_time          (drv.audio_time),
    .in_audio_eos           (drv.audio_eos),
    .in_seek_pts            (drv.seek_pts),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_current_valid      (out_current_valid),
    .out_current_handle     (out_current_handle),
    .out_dropped_count      (out_dropped_count),
    .out_seeking            (out_seeking),
    .out_can_accept         (out_can_accept),
    .out_eos_played         (out_eos_played),
    .out_queue_count        (out_queue_count),
    .out_overflow           (out_overflow),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  pacing_scoreboard sb;

  // --------------------------------------------------------------------------
  // Monitor: note accepted input items, check accepted status items. Both
  // handshakes are sampled at the rising edge, before the block updates.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pacing_status_t got;
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_command(drv);
      if (out_valid && out_ready) begin
        got.current_valid  = out_current_valid;
        got.current_handle = out_current_handle;
        got.dropped_count  = out_dropped_count;
        got.seeking        = out_seeking;
        got.can_accept     = out_can_accept;
        got.eos_played     = out_eos_played;
        got.queue_count    = out_queue_count;
        got.overflow       = out_overflow;
        sb.check_status(got);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: pick a stall mode for a random stretch of cycles; one mode
  // never stalls, the others stall randomly, on a rotating mask, or in
  // long periodic runs.
  // --------------------------------------------------------------------------
  int unsigned rx_left = 0;
  int unsigned rx_mode = 0;
  logic [7:0]  rx_mask = '0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(3);
      rx_mask = 8'($urandom);
      rx_left = $urandom_range(16, 96);
    end
    rx_left--;
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(1));
      2:       out_ready <= rx_mask[rx_left % 8];
      default: out_ready <= (rx_left % 12) < 4;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  int unsigned burst_left = 0;

  function automatic logic [TBITS-1:0] rand_time();
    return TBITS'({$urandom, $urandom});
  endfunction

  // Fill every field at random, then set the command; unused fields carry
  // noise so that the block has to ignore them.
  function automatic frame_cmd_t make_cmd(logic [2:0] cmd);
    frame_cmd_t c;
    c.command             = cmd;
    c.frame_present       = 1'($urandom_range(1));
    c.frame_handle        = HBITS'($urandom);
    c.frame_is_eos        = 1'($urandom_range(1));
    c.frame_pts           = rand_time();
    c.decoder_needs_input = 1'($urandom_range(1));
    c.audio_time          = rand_time();
    c.audio_eos           = 1'($urandom_range(1));
    c.seek_pts            = rand_time();
    return c;
  endfunction

  // Hold valid and payload from a falling edge until accepted. Bursts of
  // random length are separated by random gaps with valid low.
  task automatic send(frame_cmd_t c);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    drv      <= c;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_push(logic [HBITS-1:0] handle, logic [TBITS-1:0] pts, bit eos);
    frame_cmd_t c;
    c = make_cmd(CMD_DEC_UPDATE);
    c.frame_present = 1'b1;
    c.frame_handle  = handle;
    c.frame_pts     = pts;
    c.frame_is_eos  = eos;
    send(c);
  endtask

  task automatic send_tick(logic [TBITS-1:0] mt, bit audio_end);
    frame_cmd_t c;
    c = make_cmd(CMD_DISP_TICK);
    c.audio_time = mt;
    c.audio_eos  = audio_end;
    send(c);
  endtask

  task automatic send_seek(logic [TBITS-1:0] sp);
    frame_cmd_t c;
    c = make_cmd(CMD_SEEK);
    c.seek_pts = sp;
    send(c);
  endtask

  // Lower valid and hold until every expected status item has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Register port
  // --------------------------------------------------------------------------
  task automatic apb_access(bit wr, logic [REG_IDX_W-1:0] idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write all three registers while the block is idle, then read them back.
  task automatic set_config(int unsigned pre, int unsigned maxc, int unsigned thr);
    logic [31:0] rd;
    drain();
    repeat (DEPTH + 4) @(posedge clk);
    apb_access(1, REG_PREROLL,   32'(pre),  rd);
    apb_access(1, REG_MAX_CACHE, 32'(maxc), rd);
    apb_access(1, REG_THRESHOLD, 32'(thr),  rd);
    sb.preroll   = FRAMES_W'(pre);
    sb.max_cache = FRAMES_W'(maxc);
    sb.thresh    = THRESH_W'(thr);
    apb_access(0, REG_PREROLL, '0, rd);
    sb.check_field("preroll_frames readback", 64'(sb.preroll), 64'(rd));
    apb_access(0, REG_MAX_CACHE, '0, rd);
    sb.check_field("max_cached_frames readback", 64'(sb.max_cache), 64'(rd));
    apb_access(0, REG_THRESHOLD, '0, rd);
    sb.check_field("time_threshold readback", 64'(sb.thresh), 64'(rd));
  endtask

  // --------------------------------------------------------------------------
  // Directed corner cases, run under the reset register values
  // --------------------------------------------------------------------------
  task automatic run_directed();
    frame_cmd_t c;
    // display tick on an empty queue changes nothing
    send_tick('0, 1'b0);
    send(make_cmd(CMD_SAMPLE_WR));
    // decoder update without a frame only updates need_input
    c = make_cmd(CMD_DEC_UPDATE);
    c.frame_present       = 1'b0;
    c.decoder_needs_input = 1'b1;
    send(c);
    // extreme handles and timestamps; ticks at both ends of the time range
    send_push('1, {1'b0, {(TBITS-1){1'b1}}}, 1'b0);
    send_push('0, {1'b1, {(TBITS-1){1'b0}}}, 1'b0);
    send_tick({1'b1, {(TBITS-1){1'b0}}}, 1'b0);
    send_tick({1'b0, {(TBITS-1){1'b1}}}, 1'b0);
    // negative seek target clamps to zero; early frame discarded, then an
    // end-of-stream frame ends the seek
    send_seek({1'b1, {(TBITS-1){1'b0}}});
    send_push(16'h1234, -TBITS'(5), 1'b0);
    send_push(16'h4321, -TBITS'(5), 1'b1);
    // preroll of one ends the seek on the first frame at or past the target
    send_seek(TBITS'(1000));
    send_push(16'h00A5, TBITS'(2000), 1'b0);
    send_push(16'h005A, TBITS'(5000), 1'b0);
    send_push(16'hA55A, TBITS'(8000), 1'b0);
    // audio end keeps only the front frame
    send_tick('0, 1'b1);
    // end of stream, a sample after it, and end written again
    send(make_cmd(CMD_EOS_WR));
    send(make_cmd(CMD_SAMPLE_WR));
    send(make_cmd(CMD_EOS_WR));
    // unknown commands only report status
    send(make_cmd(3'd5));
    send(make_cmd(3'd6));
    send(make_cmd(3'd7));
    send_seek({1'b0, {(TBITS-1){1'b1}}});
    send_push(16'h0F0F, {1'b0, {(TBITS-1){1'b1}}}, 1'b0);
    send_tick({1'b0, {(TBITS-1){1'b1}}}, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Random playback session: a seek, then decoded frames on a 30 fps
  // timeline, display ticks on an advancing audio clock, samples and end of
  // stream, with occasional floods, new seeks and plain noise.
  // --------------------------------------------------------------------------
  task automatic run_session(int n_items);
    longint   t_now;
    longint   next_pts;
    longint   target;
    int       k;
    int       r;
    frame_cmd_t c;
    target = $urandom_range(0, 200000);
    send_seek(TBITS'(target));
    t_now    = target;
    next_pts = target - FRAME_T * $urandom_range(0, 3);
    for (k = 1; k < n_items; k++) begin
      r = $urandom_range(99);
      if (r < 34) begin
        send_push(HBITS'($urandom), TBITS'(next_pts), $urandom_range(19) == 0);
        next_pts = next_pts + FRAME_T + $urandom_range(0, 400) - 200;
      end else if (r < 37) begin
        // flood the queue past its depth
        repeat (18) begin
          send_push(HBITS'($urandom), TBITS'(next_pts), 1'b0);
          next_pts = next_pts + FRAME_T;
        end
        k += 17;
      end else if (r < 60) begin
        t_now = t_now + $urandom_range(0, 6000);
        if ($urandom_range(19) == 0) t_now = t_now + $urandom_range(20000, 200000);
        send_tick(TBITS'(t_now), $urandom_range(29) == 0);
      end else if (r < 68) begin
        send(make_cmd(CMD_SAMPLE_WR));
      end else if (r < 72) begin
        send(make_cmd(CMD_EOS_WR));
      end else if (r < 76) begin
        if ($urandom_range(7) == 0) target = -longint'($urandom_range(1, 1000000));
        else target = t_now + $urandom_range(0, 60000) - 30000;
        send_seek(TBITS'(target));
        t_now    = (target < 0) ? 0 : target;
        next_pts = t_now - FRAME_T * $urandom_range(0, 4);
      end else if (r < 80) begin
        c = make_cmd(CMD_DEC_UPDATE);
        c.frame_present = 1'b0;
        send(c);
      end else if (r < 82) begin
        // hold off until the block has answered everything
        drain();
        k--;
      end else begin
        send(make_cmd(3'($urandom_range(7))));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();

    // preroll of zero, a one-frame cache and no slack
    set_config(0, 1, 0);
    run_session(80);
    set_config(16, 16, 90000);
    run_session(80);
    // top of each register's range
    set_config(31, 31, 131071);
    run_session(80);
    set_config(PREROLL_RST, MAX_CACHE_RST, THRESHOLD_RST);
    run_session(80);
    repeat (2) begin
      set_config($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(0, 90000));
      run_session(80);
    end

    drain();
    repeat (DEPTH * 2) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[video_frame_pacing_queue] OK");
    end else begin
      $display("[video_frame_pacing_queue] ERROR");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run
  initial begin
    #400000;
    $display("[video_frame_pacing_queue] ERROR");
    $finish;
  end

endmodule
